// File: hw/rtl/vsne_pkg.sv
package vsne_pkg;

    // default geometry
    localparam int CHUNK_SIDE_DEF    = 8;
    localparam int SMOOTH_RADIUS_DEF = 3;

    // field widths
    localparam int POS_W = 4;
    localparam int NRM_W = 16;
    localparam int WGT_W = 16;

    // accumulator and normalization widths (cover the largest radius)
    localparam int SUM_W  = 26;
    localparam int MAG_W  = SUM_W - 1;
    localparam int SQ_W   = 2 * MAG_W + 2;
    localparam int ROOT_W = SQ_W / 2;
    localparam int DIV_W  = ROOT_W + 16;
    localparam int QUO_W  = 16;

    localparam int UNIT_Q14 = 16384;

    // input op codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_COMP  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // command kinds between front and back
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_COMP  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_ZERO  = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] z;
        logic             solid;
    } cmd_t;

    // Weight component round(2*h/s * 2^16) for odd h = 2a+1 on its own axis,
    // indexed {a_self, a_other0, a_other1}; s = sum of the three squares.
    localparam logic [WGT_W-1:0] WEIGHT_TAB [64] = '{
        16'(((1 << 18) + 3) / 6),     16'(((1 << 18) + 11) / 22),
        16'(((1 << 18) + 27) / 54),   16'(((1 << 18) + 51) / 102),
        16'(((1 << 18) + 11) / 22),   16'(((1 << 18) + 19) / 38),
        16'(((1 << 18) + 35) / 70),   16'(((1 << 18) + 59) / 118),
        16'(((1 << 18) + 27) / 54),   16'(((1 << 18) + 35) / 70),
        16'(((1 << 18) + 51) / 102),  16'(((1 << 18) + 75) / 150),
        16'(((1 << 18) + 51) / 102),  16'(((1 << 18) + 59) / 118),
        16'(((1 << 18) + 75) / 150),  16'(((1 << 18) + 99) / 198),
        16'(((3 << 18) + 11) / 22),   16'(((3 << 18) + 19) / 38),
        16'(((3 << 18) + 35) / 70),   16'(((3 << 18) + 59) / 118),
        16'(((3 << 18) + 19) / 38),   16'(((3 << 18) + 27) / 54),
        16'(((3 << 18) + 43) / 86),   16'(((3 << 18) + 67) / 134),
        16'(((3 << 18) + 35) / 70),   16'(((3 << 18) + 43) / 86),
        16'(((3 << 18) + 59) / 118),  16'(((3 << 18) + 83) / 166),
        16'(((3 << 18) + 59) / 118),  16'(((3 << 18) + 67) / 134),
        16'(((3 << 18) + 83) / 166),  16'(((3 << 18) + 107) / 214),
        16'(((5 << 18) + 27) / 54),   16'(((5 << 18) + 35) / 70),
        16'(((5 << 18) + 51) / 102),  16'(((5 << 18) + 75) / 150),
        16'(((5 << 18) + 35) / 70),   16'(((5 << 18) + 43) / 86),
        16'(((5 << 18) + 59) / 118),  16'(((5 << 18) + 83) / 166),
        16'(((5 << 18) + 51) / 102),  16'(((5 << 18) + 59) / 118),
        16'(((5 << 18) + 75) / 150),  16'(((5 << 18) + 99) / 198),
        16'(((5 << 18) + 75) / 150),  16'(((5 << 18) + 83) / 166),
        16'(((5 << 18) + 99) / 198),  16'(((5 << 18) + 123) / 246),
        16'(((7 << 18) + 51) / 102),  16'(((7 << 18) + 59) / 118),
        16'(((7 << 18) + 75) / 150),  16'(((7 << 18) + 99) / 198),
        16'(((7 << 18) + 59) / 118),  16'(((7 << 18) + 67) / 134),
        16'(((7 << 18) + 83) / 166),  16'(((7 << 18) + 107) / 214),
        16'(((7 << 18) + 75) / 150),  16'(((7 << 18) + 83) / 166),
        16'(((7 << 18) + 99) / 198),  16'(((7 << 18) + 123) / 246),
        16'(((7 << 18) + 99) / 198),  16'(((7 << 18) + 107) / 214),
        16'(((7 << 18) + 123) / 246), 16'(((7 << 18) + 147) / 294)
    };

endpackage

// File: hw/rtl/vsne_front.sv
module vsne_front #(
    parameter int CHUNK_SIDE    = vsne_pkg::CHUNK_SIDE_DEF,
    parameter int SMOOTH_RADIUS = vsne_pkg::SMOOTH_RADIUS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 op,
    input  logic [vsne_pkg::POS_W-1:0] pos_x,
    input  logic [vsne_pkg::POS_W-1:0] pos_y,
    input  logic [vsne_pkg::POS_W-1:0] pos_z,
    input  logic                       solid_bit,
    input  logic                       clr_busy,
    output vsne_pkg::cmd_t             cmd,
    output logic                       cmd_valid,
    input  logic                       cmd_ready
);

    localparam int GRID_SIDE = CHUNK_SIDE + 2 * SMOOTH_RADIUS;
    localparam logic [6:0] GRID_LIM  = 7'(GRID_SIDE);
    localparam logic [6:0] CHUNK_LIM = 7'(CHUNK_SIDE);

    logic           in_grid;
    logic           in_chunk;
    logic           keep;
    logic           push;
    logic           pop;
    vsne_pkg::cmd_t new_cmd;

    vsne_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;

    // range checks on the coordinates
    assign in_grid  = ({3'b000, pos_x} < GRID_LIM) && ({3'b000, pos_y} < GRID_LIM)
                   && ({3'b000, pos_z} < GRID_LIM);
    assign in_chunk = ({3'b000, pos_x} < CHUNK_LIM) && ({3'b000, pos_y} < CHUNK_LIM)
                   && ({3'b000, pos_z} < CHUNK_LIM);

    // classify the beat; dropped beats are taken and forgotten
    always_comb
    begin
        new_cmd.x     = pos_x;
        new_cmd.y     = pos_y;
        new_cmd.z     = pos_z;
        new_cmd.solid = solid_bit;
        new_cmd.kind  = vsne_pkg::CMD_LOAD;
        keep          = 1'b0;
        unique case (op)
            vsne_pkg::OP_LOAD:
            begin
                new_cmd.kind = vsne_pkg::CMD_LOAD;
                keep         = in_grid;
            end
            vsne_pkg::OP_COMP:
            begin
                new_cmd.kind = in_chunk ? vsne_pkg::CMD_COMP : vsne_pkg::CMD_ZERO;
                keep         = 1'b1;
            end
            vsne_pkg::OP_CLEAR:
            begin
                new_cmd.kind = vsne_pkg::CMD_CLEAR;
                keep         = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // two-entry command queue
    assign in_ready  = (cnt_reg != 2'd2) && !clr_busy;
    assign push      = in_valid && in_ready && keep;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// File: hw/rtl/vsne_norm.sv
module vsne_norm (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [vsne_pkg::SUM_W-1:0]   sum_x,
    input  logic signed [vsne_pkg::SUM_W-1:0]   sum_y,
    input  logic signed [vsne_pkg::SUM_W-1:0]   sum_z,
    output logic                                done,
    output logic signed [vsne_pkg::NRM_W-1:0]   nrm_x,
    output logic signed [vsne_pkg::NRM_W-1:0]   nrm_y,
    output logic signed [vsne_pkg::NRM_W-1:0]   nrm_z
);

    localparam int MAG_W  = vsne_pkg::MAG_W;
    localparam int SQ_W   = vsne_pkg::SQ_W;
    localparam int ROOT_W = vsne_pkg::ROOT_W;
    localparam int DIV_W  = vsne_pkg::DIV_W;
    localparam int QUO_W  = vsne_pkg::QUO_W;
    localparam int REM_W  = ROOT_W + 2;

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_SQ    = 3'd1;
    localparam logic [2:0] N_ROOT  = 3'd2;
    localparam logic [2:0] N_DPREP = 3'd3;
    localparam logic [2:0] N_DIV   = 3'd4;
    localparam logic [2:0] N_FIN   = 3'd5;

    localparam logic [QUO_W-1:0] UNIT = QUO_W'(vsne_pkg::UNIT_Q14);

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [4:0]           cnt_reg;
    logic [4:0]           cnt_next;
    logic [MAG_W-1:0]     mag_reg [3];
    logic [MAG_W-1:0]     mag_next [3];
    logic                 neg_reg [3];
    logic                 neg_next [3];
    logic [2*MAG_W-1:0]   prod_reg;
    logic [2*MAG_W-1:0]   prod_next;
    logic [SQ_W-1:0]      sq_reg;
    logic [SQ_W-1:0]      sq_next;
    logic [SQ_W-1:0]      rad_reg;
    logic [SQ_W-1:0]      rad_next;
    logic [ROOT_W-1:0]    root_reg;
    logic [ROOT_W-1:0]    root_next;
    logic [REM_W-1:0]     rem_reg;
    logic [REM_W-1:0]     rem_next;
    logic [DIV_W-1:0]     drem_reg [3];
    logic [DIV_W-1:0]     drem_next [3];
    logic [DIV_W-1:0]     dsh_reg;
    logic [DIV_W-1:0]     dsh_next;
    logic [QUO_W-1:0]     quo_reg [3];
    logic [QUO_W-1:0]     quo_next [3];

    logic [MAG_W-1:0]     mul_op;
    logic [REM_W-1:0]     rem_sh;
    logic [REM_W-1:0]     trial;
    logic [QUO_W-1:0]     clamp [3];
    logic signed [vsne_pkg::SUM_W-1:0] sum_in [3];

    assign sum_in[0] = sum_x;
    assign sum_in[1] = sum_y;
    assign sum_in[2] = sum_z;

    assign mul_op = (cnt_reg == 5'd0) ? mag_reg[0] : ((cnt_reg == 5'd1) ? mag_reg[1] : mag_reg[2]);
    assign rem_sh = {rem_reg[ROOT_W-1:0], rad_reg[SQ_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};

    // sequencer: squares, bitwise root, three parallel long divisions
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        sq_next    = sq_reg;
        rad_next   = rad_reg;
        root_next  = root_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i]  = mag_reg[i];
            neg_next[i]  = neg_reg[i];
            drem_next[i] = drem_reg[i];
            quo_next[i]  = quo_reg[i];
        end
        unique case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_next[i] = sum_in[i][vsne_pkg::SUM_W-1];
                        mag_next[i] = sum_in[i][vsne_pkg::SUM_W-1] ? MAG_W'(-sum_in[i])
                                                                  : MAG_W'(sum_in[i]);
                    end
                    sq_next    = '0;
                    cnt_next   = 5'd0;
                    state_next = N_SQ;
                end
            end
            N_SQ:
            begin
                prod_next = mul_op * mul_op;
                if (cnt_reg != 5'd0)
                begin
                    sq_next = sq_reg + SQ_W'(prod_reg);
                end
                if (cnt_reg == 5'd3)
                begin
                    rad_next   = sq_reg + SQ_W'(prod_reg);
                    root_next  = '0;
                    rem_next   = '0;
                    cnt_next   = 5'd0;
                    state_next = N_ROOT;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            N_ROOT:
            begin
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                rad_next = {rad_reg[SQ_W-3:0], 2'b00};
                if (cnt_reg == 5'(ROOT_W - 1))
                begin
                    state_next = N_DPREP;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            N_DPREP:
            begin
                // round(a*16384/len) = floor((a*32768 + len) / (2*len))
                for (int i = 0; i < 3; i++)
                begin
                    drem_next[i] = (DIV_W'(mag_reg[i]) << 15) + DIV_W'(root_reg);
                    quo_next[i]  = '0;
                end
                dsh_next = DIV_W'(root_reg) << 16;
                cnt_next = 5'd0;
                if (root_reg == '0)
                begin
                    state_next = N_FIN;
                end
                else
                begin
                    state_next = N_DIV;
                end
            end
            N_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (drem_reg[i] >= dsh_reg)
                    begin
                        drem_next[i] = drem_reg[i] - dsh_reg;
                        quo_next[i]  = {quo_reg[i][QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        quo_next[i] = {quo_reg[i][QUO_W-2:0], 1'b0};
                    end
                end
                dsh_next = dsh_reg >> 1;
                if (cnt_reg == 5'(QUO_W - 1))
                begin
                    state_next = N_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            N_FIN:
            begin
                state_next = N_IDLE;
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

    // clamp and restore sign
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            clamp[i] = (quo_reg[i] > UNIT) ? UNIT : quo_reg[i];
        end
    end

    assign done  = (state_reg == N_FIN);
    assign nrm_x = neg_reg[0] ? -$signed(clamp[0]) : $signed(clamp[0]);
    assign nrm_y = neg_reg[1] ? -$signed(clamp[1]) : $signed(clamp[1]);
    assign nrm_z = neg_reg[2] ? -$signed(clamp[2]) : $signed(clamp[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        sq_reg   <= sq_next;
        rad_reg  <= rad_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        for (int i = 0; i < 3; i++)
        begin
            mag_reg[i]  <= mag_next[i];
            neg_reg[i]  <= neg_next[i];
            drem_reg[i] <= drem_next[i];
            quo_reg[i]  <= quo_next[i];
        end
    end

endmodule

// File: hw/rtl/vsne_back.sv
module vsne_back #(
    parameter int CHUNK_SIDE    = vsne_pkg::CHUNK_SIDE_DEF,
    parameter int SMOOTH_RADIUS = vsne_pkg::SMOOTH_RADIUS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  vsne_pkg::cmd_t                    cmd,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    output logic                              clr_busy,
    output logic                              norm_start,
    output logic signed [vsne_pkg::SUM_W-1:0] sum_x,
    output logic signed [vsne_pkg::SUM_W-1:0] sum_y,
    output logic signed [vsne_pkg::SUM_W-1:0] sum_z,
    input  logic                              norm_done,
    input  logic signed [vsne_pkg::NRM_W-1:0] nrm_x,
    input  logic signed [vsne_pkg::NRM_W-1:0] nrm_y,
    input  logic signed [vsne_pkg::NRM_W-1:0] nrm_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [vsne_pkg::NRM_W-1:0] normal_x,
    output logic signed [vsne_pkg::NRM_W-1:0] normal_y,
    output logic signed [vsne_pkg::NRM_W-1:0] normal_z,
    output logic                              exposed
);

    localparam int GRID_SIDE = CHUNK_SIDE + 2 * SMOOTH_RADIUS;
    localparam int CELLS     = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int CRD_W     = $clog2(GRID_SIDE);
    localparam int SPAN      = 2 * SMOOTH_RADIUS;
    localparam int OFS_W     = (SPAN > 2) ? $clog2(SPAN) : 1;
    localparam int OW        = OFS_W + 1;
    localparam int SUM_W     = vsne_pkg::SUM_W;
    localparam int NRM_W     = vsne_pkg::NRM_W;

    localparam logic [OFS_W-1:0]  OFS_LAST  = OFS_W'(SPAN - 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(CELLS - 1);

    localparam logic [2:0] B_CLEAR  = 3'd0;
    localparam logic [2:0] B_IDLE   = 3'd1;
    localparam logic [2:0] B_CORNER = 3'd2;
    localparam logic [2:0] B_CDONE  = 3'd3;
    localparam logic [2:0] B_SWEEP  = 3'd4;
    localparam logic [2:0] B_SDONE  = 3'd5;
    localparam logic [2:0] B_NSTART = 3'd6;
    localparam logic [2:0] B_NWAIT  = 3'd7;
    localparam logic [3:0] B_OUT    = 4'd8;

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [CRD_W-1:0] x,
        input logic [CRD_W-1:0] y,
        input logic [CRD_W-1:0] z
    );
        return ADDR_W'(x) + ADDR_W'(GRID_SIDE) * (ADDR_W'(y) + ADDR_W'(GRID_SIDE) * ADDR_W'(z));
    endfunction

    // table index (|h|-1)/2 for h = 2*(i-R)+1
    function automatic logic [1:0] mag_idx(input logic [OFS_W-1:0] i);
        logic [OW-1:0] w;
        if ({1'b0, i} >= OW'(SMOOTH_RADIUS))
        begin
            w = {1'b0, i} - OW'(SMOOTH_RADIUS);
        end
        else
        begin
            w = OW'(SMOOTH_RADIUS - 1) - {1'b0, i};
        end
        return 2'(w);
    endfunction

    function automatic logic neg_idx(input logic [OFS_W-1:0] i);
        return ({1'b0, i} < OW'(SMOOTH_RADIUS));
    endfunction

    // control state
    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic [2:0]        cor_cnt_reg;
    logic [2:0]        cor_cnt_next;
    logic [OFS_W-1:0]  ix_reg;
    logic [OFS_W-1:0]  ix_next;
    logic [OFS_W-1:0]  iy_reg;
    logic [OFS_W-1:0]  iy_next;
    logic [OFS_W-1:0]  iz_reg;
    logic [OFS_W-1:0]  iz_next;
    logic              rd_v_reg;
    logic              rd_v_next;

    // payload
    logic [vsne_pkg::POS_W-1:0] px_reg;
    logic [vsne_pkg::POS_W-1:0] px_next;
    logic [vsne_pkg::POS_W-1:0] py_reg;
    logic [vsne_pkg::POS_W-1:0] py_next;
    logic [vsne_pkg::POS_W-1:0] pz_reg;
    logic [vsne_pkg::POS_W-1:0] pz_next;
    logic              ref_reg;
    logic              ref_next;
    logic              expo_reg;
    logic              expo_next;
    logic signed [SUM_W-1:0] sx_reg;
    logic signed [SUM_W-1:0] sx_next;
    logic signed [SUM_W-1:0] sy_reg;
    logic signed [SUM_W-1:0] sy_next;
    logic signed [SUM_W-1:0] sz_reg;
    logic signed [SUM_W-1:0] sz_next;
    logic signed [NRM_W-1:0] res_x_reg;
    logic signed [NRM_W-1:0] res_x_next;
    logic signed [NRM_W-1:0] res_y_reg;
    logic signed [NRM_W-1:0] res_y_next;
    logic signed [NRM_W-1:0] res_z_reg;
    logic signed [NRM_W-1:0] res_z_next;
    logic              res_exp_reg;
    logic              res_exp_next;
    logic              rd_sweep_reg;
    logic              rd_sweep_next;
    logic              rd_first_reg;
    logic              rd_first_next;
    logic [OFS_W-1:0]  tix_reg;
    logic [OFS_W-1:0]  tiy_reg;
    logic [OFS_W-1:0]  tiz_reg;
    logic              rd_data_reg;
    logic              grid_reg [CELLS];

    // memory ports
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic              mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [ADDR_W-1:0] cor_addr;
    logic [ADDR_W-1:0] swp_addr;

    // weight lookup on the returning sweep beat
    logic [1:0]               ax;
    logic [1:0]               ay;
    logic [1:0]               az;
    logic [vsne_pkg::WGT_W-1:0] wx;
    logic [vsne_pkg::WGT_W-1:0] wy;
    logic [vsne_pkg::WGT_W-1:0] wz;
    logic signed [SUM_W-1:0]  ex;
    logic signed [SUM_W-1:0]  ey;
    logic signed [SUM_W-1:0]  ez;
    logic signed [SUM_W-1:0]  term_x;
    logic signed [SUM_W-1:0]  term_y;
    logic signed [SUM_W-1:0]  term_z;

    assign ax = mag_idx(tix_reg);
    assign ay = mag_idx(tiy_reg);
    assign az = mag_idx(tiz_reg);
    assign wx = vsne_pkg::WEIGHT_TAB[{ax, ay, az}];
    assign wy = vsne_pkg::WEIGHT_TAB[{ay, ax, az}];
    assign wz = vsne_pkg::WEIGHT_TAB[{az, ax, ay}];
    assign ex = SUM_W'(wx);
    assign ey = SUM_W'(wy);
    assign ez = SUM_W'(wz);
    assign term_x = neg_idx(tix_reg) ? -ex : ex;
    assign term_y = neg_idx(tiy_reg) ? -ey : ey;
    assign term_z = neg_idx(tiz_reg) ? -ez : ez;

    // read addresses: corner cube and neighborhood sweep
    assign cor_addr = cell_addr(
        CRD_W'(px_reg) + CRD_W'(SMOOTH_RADIUS - 1) + CRD_W'(cor_cnt_reg[0]),
        CRD_W'(py_reg) + CRD_W'(SMOOTH_RADIUS - 1) + CRD_W'(cor_cnt_reg[1]),
        CRD_W'(pz_reg) + CRD_W'(SMOOTH_RADIUS - 1) + CRD_W'(cor_cnt_reg[2]));
    assign swp_addr = cell_addr(CRD_W'(px_reg) + CRD_W'(ix_reg),
                                CRD_W'(py_reg) + CRD_W'(iy_reg),
                                CRD_W'(pz_reg) + CRD_W'(iz_reg));
    assign mem_raddr = (state_reg == {1'b0, B_SWEEP}) ? swp_addr : cor_addr;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        cor_cnt_next  = cor_cnt_reg;
        ix_next       = ix_reg;
        iy_next       = iy_reg;
        iz_next       = iz_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        pz_next       = pz_reg;
        ref_next      = ref_reg;
        expo_next     = expo_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        sz_next       = sz_reg;
        res_x_next    = res_x_reg;
        res_y_next    = res_y_reg;
        res_z_next    = res_z_reg;
        res_exp_next  = res_exp_reg;
        rd_v_next     = 1'b0;
        rd_sweep_next = 1'b0;
        rd_first_next = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = clr_addr_reg;
        mem_wdata     = 1'b0;
        cmd_ready     = 1'b0;
        norm_start    = 1'b0;

        // corner beat returning: first sets the reference, others compare
        if (rd_v_reg && !rd_sweep_reg)
        begin
            if (rd_first_reg)
            begin
                ref_next = rd_data_reg;
            end
            else if (rd_data_reg != ref_reg)
            begin
                expo_next = 1'b1;
            end
        end

        // sweep beat returning: empty voxels add their weight
        if (rd_v_reg && rd_sweep_reg && !rd_data_reg)
        begin
            sx_next = sx_reg + term_x;
            sy_next = sy_reg + term_y;
            sz_next = sz_reg + term_z;
        end

        unique case (state_reg)
            {1'b0, B_CLEAR}:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = 1'b0;
                if (clr_addr_reg == ADDR_LAST)
                begin
                    state_next = {1'b0, B_IDLE};
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            {1'b0, B_IDLE}:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    unique case (cmd.kind)
                        vsne_pkg::CMD_LOAD:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = cell_addr(CRD_W'(cmd.x), CRD_W'(cmd.y), CRD_W'(cmd.z));
                            mem_wdata = cmd.solid;
                        end
                        vsne_pkg::CMD_CLEAR:
                        begin
                            clr_addr_next = '0;
                            state_next    = {1'b0, B_CLEAR};
                        end
                        vsne_pkg::CMD_COMP:
                        begin
                            px_next      = cmd.x;
                            py_next      = cmd.y;
                            pz_next      = cmd.z;
                            expo_next    = 1'b0;
                            sx_next      = '0;
                            sy_next      = '0;
                            sz_next      = '0;
                            cor_cnt_next = 3'd0;
                            state_next   = {1'b0, B_CORNER};
                        end
                        default:
                        begin
                            res_x_next   = '0;
                            res_y_next   = '0;
                            res_z_next   = '0;
                            res_exp_next = 1'b0;
                            state_next   = B_OUT;
                        end
                    endcase
                end
            end
            {1'b0, B_CORNER}:
            begin
                rd_v_next     = 1'b1;
                rd_first_next = (cor_cnt_reg == 3'd0);
                cor_cnt_next  = cor_cnt_reg + 3'd1;
                if (cor_cnt_reg == 3'd7)
                begin
                    state_next = {1'b0, B_CDONE};
                end
            end
            {1'b0, B_CDONE}:
            begin
                if (expo_next)
                begin
                    ix_next    = '0;
                    iy_next    = '0;
                    iz_next    = '0;
                    state_next = {1'b0, B_SWEEP};
                end
                else
                begin
                    res_x_next   = '0;
                    res_y_next   = '0;
                    res_z_next   = '0;
                    res_exp_next = 1'b0;
                    state_next   = B_OUT;
                end
            end
            {1'b0, B_SWEEP}:
            begin
                rd_v_next     = 1'b1;
                rd_sweep_next = 1'b1;
                if (ix_reg == OFS_LAST)
                begin
                    ix_next = '0;
                    if (iy_reg == OFS_LAST)
                    begin
                        iy_next = '0;
                        if (iz_reg == OFS_LAST)
                        begin
                            state_next = {1'b0, B_SDONE};
                        end
                        else
                        begin
                            iz_next = iz_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        iy_next = iy_reg + 1'b1;
                    end
                end
                else
                begin
                    ix_next = ix_reg + 1'b1;
                end
            end
            {1'b0, B_SDONE}:
            begin
                state_next = {1'b0, B_NSTART};
            end
            {1'b0, B_NSTART}:
            begin
                norm_start = 1'b1;
                state_next = {1'b0, B_NWAIT};
            end
            {1'b0, B_NWAIT}:
            begin
                if (norm_done)
                begin
                    res_x_next   = nrm_x;
                    res_y_next   = nrm_y;
                    res_z_next   = nrm_z;
                    res_exp_next = 1'b1;
                    state_next   = B_OUT;
                end
            end
            B_OUT:
            begin
                if (out_ready)
                begin
                    state_next = {1'b0, B_IDLE};
                end
            end
            default:
            begin
                state_next = {1'b0, B_IDLE};
            end
        endcase
    end

    assign clr_busy  = (state_reg == {1'b0, B_CLEAR});
    assign out_valid = (state_reg == B_OUT);
    assign normal_x  = res_x_reg;
    assign normal_y  = res_y_reg;
    assign normal_z  = res_z_reg;
    assign exposed   = res_exp_reg;
    assign sum_x     = sx_reg;
    assign sum_y     = sy_reg;
    assign sum_z     = sz_reg;

    // grid memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_reg[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= grid_reg[mem_raddr];
    end

    // control registers; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= {1'b0, B_CLEAR};
            clr_addr_reg <= '0;
            cor_cnt_reg  <= 3'd0;
            ix_reg       <= '0;
            iy_reg       <= '0;
            iz_reg       <= '0;
            rd_v_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            cor_cnt_reg  <= cor_cnt_next;
            ix_reg       <= ix_next;
            iy_reg       <= iy_next;
            iz_reg       <= iz_next;
            rd_v_reg     <= rd_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg       <= px_next;
        py_reg       <= py_next;
        pz_reg       <= pz_next;
        ref_reg      <= ref_next;
        expo_reg     <= expo_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        sz_reg       <= sz_next;
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        res_z_reg    <= res_z_next;
        res_exp_reg  <= res_exp_next;
        rd_sweep_reg <= rd_sweep_next;
        rd_first_reg <= rd_first_next;
        tix_reg      <= ix_reg;
        tiy_reg      <= iy_reg;
        tiz_reg      <= iz_reg;
    end

endmodule

// File: hw/rtl/voxel_surface_normal_estimator.sv
// Voxel surface normal estimator. Holds a padded occupancy grid of
// (CHUNK_SIDE + 2*SMOOTH_RADIUS)^3 bits in a single-port-write, registered-read
// memory. Beats with op 0 write one bit, op 2 empties the grid, op 1 returns the
// Q1.14 normal of a chunk voxel. A front stage classifies beats into a
// registered two-entry command queue; a back stage executes them. Loads
// retire one per cycle while the back stage is idle. A compute beat reads
// its 8-voxel corner cube, then, if the cube is mixed, one neighborhood voxel
// per cycle ((2*SMOOTH_RADIUS)^3 reads, 216 at the default radius), then
// normalizes: the squares, a bit-serial square root, a setup state, three
// parallel long dividers (skipped for a zero length) and a finish state.
// After reset and after every clear beat the grid is swept to zero one cell
// per cycle; no beat is taken meanwhile.
module voxel_surface_normal_estimator #(
    parameter int CHUNK_SIDE    = vsne_pkg::CHUNK_SIDE_DEF,
    parameter int SMOOTH_RADIUS = vsne_pkg::SMOOTH_RADIUS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        op,
    input  logic [vsne_pkg::POS_W-1:0]        pos_x,
    input  logic [vsne_pkg::POS_W-1:0]        pos_y,
    input  logic [vsne_pkg::POS_W-1:0]        pos_z,
    input  logic                              solid_bit,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [vsne_pkg::NRM_W-1:0] normal_x,
    output logic signed [vsne_pkg::NRM_W-1:0] normal_y,
    output logic signed [vsne_pkg::NRM_W-1:0] normal_z,
    output logic                              exposed
);

    vsne_pkg::cmd_t                    cmd;
    logic                              cmd_valid;
    logic                              cmd_ready;
    logic                              clr_busy;
    logic                              norm_start;
    logic                              norm_done;
    logic signed [vsne_pkg::SUM_W-1:0] sum_x;
    logic signed [vsne_pkg::SUM_W-1:0] sum_y;
    logic signed [vsne_pkg::SUM_W-1:0] sum_z;
    logic signed [vsne_pkg::NRM_W-1:0] nrm_x;
    logic signed [vsne_pkg::NRM_W-1:0] nrm_y;
    logic signed [vsne_pkg::NRM_W-1:0] nrm_z;

    // beat intake and command queue
    vsne_front #(
        .CHUNK_SIDE    (CHUNK_SIDE),
        .SMOOTH_RADIUS (SMOOTH_RADIUS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .solid_bit (solid_bit),
        .clr_busy  (clr_busy),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready)
    );

    // grid, sweep and result register
    vsne_back #(
        .CHUNK_SIDE    (CHUNK_SIDE),
        .SMOOTH_RADIUS (SMOOTH_RADIUS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .clr_busy   (clr_busy),
        .norm_start (norm_start),
        .sum_x      (sum_x),
        .sum_y      (sum_y),
        .sum_z      (sum_z),
        .norm_done  (norm_done),
        .nrm_x      (nrm_x),
        .nrm_y      (nrm_y),
        .nrm_z      (nrm_z),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .normal_x   (normal_x),
        .normal_y   (normal_y),
        .normal_z   (normal_z),
        .exposed    (exposed)
    );

    // length and scaling
    vsne_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .sum_x (sum_x),
        .sum_y (sum_y),
        .sum_z (sum_z),
        .done  (norm_done),
        .nrm_x (nrm_x),
        .nrm_y (nrm_y),
        .nrm_z (nrm_z)
    );

endmodule
